// ===== design/ray_triangle_nearest_hit_assert.svh =====
// Assertion macros for the ray_triangle_nearest_hit block.
`ifndef RAY_TRIANGLE_NEAREST_HIT_ASSERT_SVH
`define RAY_TRIANGLE_NEAREST_HIT_ASSERT_SVH
`ifndef SYNTH
`define RTNH_ASSERT_SAME(label, clk, rst_n, cond, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
    else $error("same-cycle check failed");
`define RTNH_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
    else $error("next-cycle check failed");
`else
`define RTNH_ASSERT_SAME(label, clk, rst_n, cond, expr)
`define RTNH_ASSERT_NEXT(label, clk, rst_n, cond, expr)
`endif
`endif

// ===== design/rtnh_pkg.sv =====
// Package: types, commands and constants of the ray triangle nearest hit block.
`timescale 1ns / 1ps
package rtnh_pkg;
  localparam int MaxTriangles  = 65536;
  localparam int CountLimitInt = ((MaxTriangles - 1) > 65535) ? 65535 : (MaxTriangles - 1);
  localparam logic [15:0] CountLimit = 16'(CountLimitInt);

  localparam logic [2:0] CfgNearX = 3'd0;
  localparam logic [2:0] CfgNearY = 3'd1;
  localparam logic [2:0] CfgNearZ = 3'd2;
  localparam logic [2:0] CfgFarX  = 3'd3;
  localparam logic [2:0] CfgFarY  = 3'd4;
  localparam logic [2:0] CfgFarZ  = 3'd5;

  localparam logic [3:0] LastStep  = 4'd8;
  localparam logic [3:0] DotStep0  = 4'd6;
  localparam logic [2:0] LastVol   = 3'd4;
  localparam logic [1:0] LastAxis  = 2'd2;

  typedef logic [31:0] coord_t;
  typedef coord_t [2:0] vec_t;

  typedef enum logic [1:0] {MO_CROSS, MO_DOT, MO_SCALE, MO_SQ} mulop_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_VLOAD, ST_XMUL, ST_XWAIT, ST_XACC, ST_VSTORE, ST_DECIDE,
    ST_DMUL, ST_DWAIT, ST_DIVL, ST_DIVW, ST_ROUND, ST_QMUL, ST_QWAIT, ST_QACC,
    ST_SQRTL, ST_SQRTW, ST_UPDATE, ST_FINISH
  } state_t;

  typedef struct packed {
    logic       load_tri;
    logic       vol_load;
    logic       mul_load;
    logic       acc;
    mulop_t     op;
    logic [2:0] idx;
    logic       vol_store;
    logic       numden;
    logic       div_load;
    logic       round_store;
    logic       sqrt_load;
    logic       update;
    logic       out_load;
    logic       tri_done;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic sqrt_done;
    logic hit;
    logic last;
    logic out_free;
  } stat_t;
endpackage

// ===== design/rtnh_ctrl.sv =====
// Controller: sequences volumes, crossing point, distance and result per triangle.
`timescale 1ns / 1ps
module rtnh_ctrl import rtnh_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_stall,
  input  stat_t stat,
  output cmd_t  cmd
);
  state_t     state_r, state_nxt;
  logic [3:0] step_r, step_nxt;
  logic [2:0] vol_r, vol_nxt;
  logic [1:0] axis_r, axis_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
      vol_r   <= '0;
      axis_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      vol_r   <= vol_nxt;
      axis_r  <= axis_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    vol_nxt   = vol_r;
    axis_nxt  = axis_r;
    cmd       = '0;
    cmd.op    = MO_CROSS;
    in_stall  = 1'b1;
    if (step_r < DotStep0) begin
      cmd.op  = MO_CROSS;
      cmd.idx = step_r[2:0];
    end else begin
      cmd.op  = MO_DOT;
      cmd.idx = 3'(step_r - DotStep0);
    end
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load_tri = 1'b1;
          vol_nxt      = '0;
          state_nxt    = ST_VLOAD;
        end
      end
      ST_VLOAD: begin
        cmd.vol_load = 1'b1;
        cmd.idx      = vol_r;
        step_nxt     = '0;
        state_nxt    = ST_XMUL;
      end
      ST_XMUL: begin
        cmd.mul_load = 1'b1;
        state_nxt    = ST_XWAIT;
      end
      ST_XWAIT: begin
        if (stat.mul_done) state_nxt = ST_XACC;
      end
      ST_XACC: begin
        cmd.acc = 1'b1;
        if (step_r == LastStep) begin
          state_nxt = ST_VSTORE;
        end else begin
          step_nxt  = step_r + 4'd1;
          state_nxt = ST_XMUL;
        end
      end
      ST_VSTORE: begin
        cmd.vol_store = 1'b1;
        cmd.idx       = vol_r;
        if (vol_r == LastVol) begin
          state_nxt = ST_DECIDE;
        end else begin
          vol_nxt   = vol_r + 3'd1;
          state_nxt = ST_VLOAD;
        end
      end
      ST_DECIDE: begin
        cmd.numden = 1'b1;
        axis_nxt   = '0;
        state_nxt  = stat.hit ? ST_DMUL : ST_FINISH;
      end
      ST_DMUL: begin
        cmd.mul_load = 1'b1;
        cmd.op       = MO_SCALE;
        cmd.idx      = {1'b0, axis_r};
        state_nxt    = ST_DWAIT;
      end
      ST_DWAIT: begin
        if (stat.mul_done) state_nxt = ST_DIVL;
      end
      ST_DIVL: begin
        cmd.div_load = 1'b1;
        state_nxt    = ST_DIVW;
      end
      ST_DIVW: begin
        if (stat.div_done) state_nxt = ST_ROUND;
      end
      ST_ROUND: begin
        cmd.round_store = 1'b1;
        cmd.idx         = {1'b0, axis_r};
        state_nxt       = ST_QMUL;
      end
      ST_QMUL: begin
        cmd.mul_load = 1'b1;
        cmd.op       = MO_SQ;
        cmd.idx      = {1'b0, axis_r};
        state_nxt    = ST_QWAIT;
      end
      ST_QWAIT: begin
        if (stat.mul_done) state_nxt = ST_QACC;
      end
      ST_QACC: begin
        cmd.acc = 1'b1;
        cmd.op  = MO_SQ;
        cmd.idx = {1'b0, axis_r};
        if (axis_r == LastAxis) begin
          state_nxt = ST_SQRTL;
        end else begin
          axis_nxt  = axis_r + 2'd1;
          state_nxt = ST_DMUL;
        end
      end
      ST_SQRTL: begin
        cmd.sqrt_load = 1'b1;
        state_nxt     = ST_SQRTW;
      end
      ST_SQRTW: begin
        if (stat.sqrt_done) state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = ST_FINISH;
      end
      ST_FINISH: begin
        if (!stat.last) begin
          cmd.tri_done = 1'b1;
          state_nxt    = ST_IDLE;
        end else if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.tri_done = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule

// ===== design/rtnh_dp.sv =====
// Datapath: segment registers, shared multiplier, divider, square root, best hit, output.
`timescale 1ns / 1ps
module rtnh_dp import rtnh_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  vec_t        in_a,
  input  vec_t        in_b,
  input  vec_t        in_c,
  input  logic        in_last,
  input  cmd_t        cmd,
  output stat_t       stat,
  input  logic        out_stall,
  output logic        out_valid,
  output logic        hit_found,
  output logic [15:0] hit_index,
  output logic [31:0] hit_x,
  output logic [31:0] hit_y,
  output logic [31:0] hit_z,
  output logic [31:0] hit_distance
);
  vec_t near_r, far_r, ta_r, tb_r, tc_r;
  logic last_r;

  logic [2:0][32:0] u_r, v_r, w_r, u_nxt, v_nxt, w_nxt;
  logic [2:0][32:0] dvec;
  logic [2:0][65:0] c_r;
  logic [99:0]      vol_r, wn_r, wf_r, num_r, den_r;
  logic [2:0]       sg_r;

  logic [127:0] ma_r;
  logic [31:0]  mb_r;
  logic         mneg_r, mbusy_r;
  logic [2:0]   mcnt_r;
  logic [63:0]  pp_r;
  logic [131:0] prod_r, pp_sh, sp;

  logic [99:0] rem_r;
  logic [31:0] dlow_r, quo_r;
  logic [4:0]  dcnt_r;
  logic        dbusy_r;

  logic [2:0][31:0] q_r;
  vec_t             pt_r;
  logic [65:0]      sq_r;

  logic [63:0] sx_r;
  logic [33:0] srem_r;
  logic [31:0] sres_r;
  logic [4:0]  scnt_r;
  logic        sbusy_r, ssat_r;

  logic        bvalid_r;
  logic [31:0] bdist_r;
  logic [15:0] bidx_r, count_r;
  vec_t        bpt_r;

  logic        ov_r, ofound_r;
  logic [15:0] oidx_r;
  vec_t        opt_r;
  logic [31:0] odist_r;

  vec_t         vp, vq, vr, vs;
  logic [100:0] opa, maga;
  logic [33:0]  opb, magb;
  logic [100:0] dtrial;
  logic         dge;
  logic [100:0] wdiff, wdmag;
  logic         rnd;
  logic [31:0]  qr, qsgn, ptk;
  logic         dneg;
  logic [35:0]  sr2, strial;
  logic         sge;
  logic [31:0]  new_dist;
  logic         better;

  always_comb begin
    vp = near_r; vq = ta_r; vr = tb_r; vs = tc_r;
    case (cmd.idx)
      3'd1: begin vp = far_r; vq = ta_r; vr = tb_r; vs = tc_r; end
      3'd2: begin vp = near_r; vq = far_r; vr = ta_r; vs = tb_r; end
      3'd3: begin vp = near_r; vq = far_r; vr = tb_r; vs = tc_r; end
      3'd4: begin vp = near_r; vq = far_r; vr = tc_r; vs = ta_r; end
      default: begin vp = near_r; vq = ta_r; vr = tb_r; vs = tc_r; end
    endcase
    for (int i = 0; i < 3; i++) begin
      u_nxt[i] = {vq[i][31], vq[i]} - {vp[i][31], vp[i]};
      v_nxt[i] = {vr[i][31], vr[i]} - {vp[i][31], vp[i]};
      w_nxt[i] = {vs[i][31], vs[i]} - {vp[i][31], vp[i]};
      dvec[i]  = {far_r[i][31], far_r[i]} - {near_r[i][31], near_r[i]};
    end
  end

  // multiplier operand select
  always_comb begin
    opa = '0;
    opb = '0;
    case (cmd.op)
      MO_CROSS: begin
        case (cmd.idx)
          3'd0: begin opa = {{68{u_r[1][32]}}, u_r[1]}; opb = {v_r[2][32], v_r[2]}; end
          3'd1: begin opa = {{68{u_r[2][32]}}, u_r[2]}; opb = {v_r[1][32], v_r[1]}; end
          3'd2: begin opa = {{68{u_r[2][32]}}, u_r[2]}; opb = {v_r[0][32], v_r[0]}; end
          3'd3: begin opa = {{68{u_r[0][32]}}, u_r[0]}; opb = {v_r[2][32], v_r[2]}; end
          3'd4: begin opa = {{68{u_r[0][32]}}, u_r[0]}; opb = {v_r[1][32], v_r[1]}; end
          3'd5: begin opa = {{68{u_r[1][32]}}, u_r[1]}; opb = {v_r[0][32], v_r[0]}; end
          default: begin opa = '0; opb = '0; end
        endcase
      end
      MO_DOT: begin
        case (cmd.idx)
          3'd0: begin opa = {{35{c_r[0][65]}}, c_r[0]}; opb = {w_r[0][32], w_r[0]}; end
          3'd1: begin opa = {{35{c_r[1][65]}}, c_r[1]}; opb = {w_r[1][32], w_r[1]}; end
          3'd2: begin opa = {{35{c_r[2][65]}}, c_r[2]}; opb = {w_r[2][32], w_r[2]}; end
          default: begin opa = '0; opb = '0; end
        endcase
      end
      MO_SCALE: begin
        opa = {1'b0, num_r};
        case (cmd.idx)
          3'd0: opb = {dvec[0][32], dvec[0]};
          3'd1: opb = {dvec[1][32], dvec[1]};
          3'd2: opb = {dvec[2][32], dvec[2]};
          default: opb = '0;
        endcase
      end
      MO_SQ: begin
        case (cmd.idx)
          3'd0: begin opa = {69'b0, q_r[0]}; opb = {2'b0, q_r[0]}; end
          3'd1: begin opa = {69'b0, q_r[1]}; opb = {2'b0, q_r[1]}; end
          3'd2: begin opa = {69'b0, q_r[2]}; opb = {2'b0, q_r[2]}; end
          default: begin opa = '0; opb = '0; end
        endcase
      end
      default: begin opa = '0; opb = '0; end
    endcase
    maga = opa[100] ? (~opa + 101'd1) : opa;
    magb = opb[33] ? (~opb + 34'd1) : opb;
  end

  assign pp_sh = {68'b0, pp_r} << {(mcnt_r - 3'd1), 5'b0};
  assign sp    = mneg_r ? (~prod_r + 132'd1) : prod_r;

  assign dtrial = {rem_r, dlow_r[31]};
  assign dge    = dtrial >= {1'b0, den_r};
  assign wdiff  = {wn_r[99], wn_r} - {wf_r[99], wf_r};
  assign wdmag  = wdiff[100] ? (~wdiff + 101'd1) : wdiff;
  assign rnd    = {rem_r, 1'b0} >= {1'b0, den_r};
  assign qr     = quo_r + {31'b0, rnd};

  always_comb begin
    case (cmd.idx)
      3'd1: begin dneg = dvec[1][32]; ptk = near_r[1]; end
      3'd2: begin dneg = dvec[2][32]; ptk = near_r[2]; end
      default: begin dneg = dvec[0][32]; ptk = near_r[0]; end
    endcase
    qsgn = dneg ? (~qr + 32'd1) : qr;
  end

  assign sr2      = {srem_r, sx_r[63:62]};
  assign strial   = {2'b0, sres_r, 2'b01};
  assign sge      = sr2 >= strial;
  assign new_dist = ssat_r ? 32'hFFFF_FFFF : sres_r;
  assign better   = !bvalid_r || (new_dist < bdist_r);

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      near_r   <= '0;
      far_r    <= '0;
      mbusy_r  <= 1'b0;
      mcnt_r   <= '0;
      dbusy_r  <= 1'b0;
      dcnt_r   <= '0;
      sbusy_r  <= 1'b0;
      scnt_r   <= '0;
      bvalid_r <= 1'b0;
      count_r  <= '0;
      ov_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CfgNearX: near_r[0] <= cfg_data;
          CfgNearY: near_r[1] <= cfg_data;
          CfgNearZ: near_r[2] <= cfg_data;
          CfgFarX:  far_r[0]  <= cfg_data;
          CfgFarY:  far_r[1]  <= cfg_data;
          CfgFarZ:  far_r[2]  <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.mul_load) begin
        mbusy_r <= 1'b1;
        mcnt_r  <= '0;
      end else if (mbusy_r) begin
        mcnt_r <= mcnt_r + 3'd1;
        if (mcnt_r == 3'd4) mbusy_r <= 1'b0;
      end
      if (cmd.div_load) begin
        dbusy_r <= 1'b1;
        dcnt_r  <= '0;
      end else if (dbusy_r) begin
        dcnt_r <= dcnt_r + 5'd1;
        if (dcnt_r == 5'd31) dbusy_r <= 1'b0;
      end
      if (cmd.sqrt_load) begin
        sbusy_r <= 1'b1;
        scnt_r  <= '0;
      end else if (sbusy_r) begin
        scnt_r <= scnt_r + 5'd1;
        if (scnt_r == 5'd31) sbusy_r <= 1'b0;
      end
      if (cmd.update && better) bvalid_r <= 1'b1;
      if (cmd.tri_done) begin
        if (last_r) begin
          bvalid_r <= 1'b0;
          count_r  <= '0;
        end else if (count_r != CountLimit) begin
          count_r <= count_r + 16'd1;
        end
      end
      ov_r <= cmd.out_load | (ov_r & out_stall);
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load_tri) begin
      ta_r   <= in_a;
      tb_r   <= in_b;
      tc_r   <= in_c;
      last_r <= in_last;
    end
    if (cmd.vol_load) begin
      u_r <= u_nxt;
      v_r <= v_nxt;
      w_r <= w_nxt;
    end
    if (cmd.mul_load) begin
      ma_r   <= {28'b0, maga[99:0]};
      mb_r   <= magb[31:0];
      mneg_r <= opa[100] ^ opb[33];
      prod_r <= '0;
    end else if (mbusy_r) begin
      pp_r <= ma_r[31:0] * mb_r;
      ma_r <= ma_r >> 32;
      if (mcnt_r != 3'd0) prod_r <= prod_r + pp_sh;
    end
    if (cmd.acc) begin
      case (cmd.op)
        MO_CROSS: begin
          case (cmd.idx)
            3'd0: c_r[0] <= sp[65:0];
            3'd1: c_r[0] <= c_r[0] - sp[65:0];
            3'd2: c_r[1] <= sp[65:0];
            3'd3: c_r[1] <= c_r[1] - sp[65:0];
            3'd4: c_r[2] <= sp[65:0];
            3'd5: c_r[2] <= c_r[2] - sp[65:0];
            default: ;
          endcase
        end
        MO_DOT: vol_r <= ((cmd.idx == 3'd0) ? 100'b0 : vol_r) + sp[99:0];
        MO_SQ:  sq_r  <= ((cmd.idx == 3'd0) ? 66'b0 : sq_r) + prod_r[65:0];
        default: ;
      endcase
    end
    if (cmd.vol_store) begin
      case (cmd.idx)
        3'd0: wn_r     <= vol_r;
        3'd1: wf_r     <= vol_r;
        3'd2: sg_r[0]  <= vol_r[99];
        3'd3: sg_r[1]  <= vol_r[99];
        3'd4: sg_r[2]  <= vol_r[99];
        default: ;
      endcase
    end
    if (cmd.numden) begin
      num_r <= wn_r[99] ? (~wn_r + 100'd1) : wn_r;
      den_r <= wdmag[99:0];
    end
    if (cmd.div_load) begin
      rem_r  <= prod_r[131:32];
      dlow_r <= prod_r[31:0];
      quo_r  <= '0;
    end else if (dbusy_r) begin
      rem_r  <= dge ? 100'(dtrial - {1'b0, den_r}) : dtrial[99:0];
      quo_r  <= {quo_r[30:0], dge};
      dlow_r <= dlow_r << 1;
    end
    if (cmd.round_store) begin
      case (cmd.idx)
        3'd1: begin q_r[1] <= qr; pt_r[1] <= ptk + qsgn; end
        3'd2: begin q_r[2] <= qr; pt_r[2] <= ptk + qsgn; end
        default: begin q_r[0] <= qr; pt_r[0] <= ptk + qsgn; end
      endcase
    end
    if (cmd.sqrt_load) begin
      sx_r   <= sq_r[63:0];
      srem_r <= '0;
      sres_r <= '0;
      ssat_r <= |sq_r[65:64];
    end else if (sbusy_r) begin
      srem_r <= sge ? 34'(sr2 - strial) : sr2[33:0];
      sres_r <= {sres_r[30:0], sge};
      sx_r   <= sx_r << 2;
    end
    if (cmd.update && better) begin
      bdist_r <= new_dist;
      bidx_r  <= count_r;
      bpt_r   <= pt_r;
    end
    if (cmd.out_load) begin
      ofound_r <= bvalid_r;
      oidx_r   <= bvalid_r ? bidx_r : 16'd0;
      opt_r    <= bvalid_r ? bpt_r : '0;
      odist_r  <= bvalid_r ? bdist_r : 32'd0;
    end
  end

  assign stat.mul_done  = mbusy_r && (mcnt_r == 3'd4);
  assign stat.div_done  = dbusy_r && (dcnt_r == 5'd31);
  assign stat.sqrt_done = sbusy_r && (scnt_r == 5'd31);
  assign stat.hit       = (wn_r[99] != wf_r[99]) && (sg_r[0] == sg_r[1]) && (sg_r[1] == sg_r[2]);
  assign stat.last      = last_r;
  assign stat.out_free  = !ov_r || !out_stall;

  assign out_valid    = ov_r;
  assign hit_found    = ofound_r;
  assign hit_index    = oidx_r;
  assign hit_x        = opt_r[0];
  assign hit_y        = opt_r[1];
  assign hit_z        = opt_r[2];
  assign hit_distance = odist_r;
endmodule

// ===== design/ray_triangle_nearest_hit.sv =====
// Top level: nearest hit of a configured ray segment against a triangle stream.
//
// Usage: write near_x..far_z (index 0..5) on the cfg channel while idle; cfg_ready is
// always high and other indexes are ignored. Send triangles on the in channel, one
// transaction each (vertices a, b, c in signed Q16.16, last_triangle on the final one).
// The block takes one triangle at a time. The work is paced by the shared 32x32
// multiplier, which builds each volume product from 32-bit chunks, and by the
// bit-serial divider and square root (once per axis and once per hit). in_stall
// is high while a triangle is in work.
// The last triangle produces one out transaction: hit flag, index, point and distance;
// the kept hit is then cleared. The result sits in an output register, so a new
// triangle is taken while out_stall holds the result; only a second result waits.
// Reset (rst_n low, synchronous) clears the segment registers, the kept hit, the
// triangle count and the output valid.
`timescale 1ns / 1ps
`include "ray_triangle_nearest_hit_assert.svh"
module ray_triangle_nearest_hit import rtnh_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_ax,
  input  logic signed [31:0] in_ay,
  input  logic signed [31:0] in_az,
  input  logic signed [31:0] in_bx,
  input  logic signed [31:0] in_by,
  input  logic signed [31:0] in_bz,
  input  logic signed [31:0] in_cx,
  input  logic signed [31:0] in_cy,
  input  logic signed [31:0] in_cz,
  input  logic               in_last_triangle,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_hit_found,
  output logic        [15:0] out_hit_index,
  output logic signed [31:0] out_hit_x,
  output logic signed [31:0] out_hit_y,
  output logic signed [31:0] out_hit_z,
  output logic        [31:0] out_hit_distance,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic        [2:0]  cfg_index,
  input  logic        [31:0] cfg_data
);
  cmd_t  cmd;
  stat_t stat;
  logic  in_accept;

  assign cfg_ready = 1'b1;
  assign in_accept = in_valid && !in_stall;

  rtnh_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  rtnh_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_a         ({in_az, in_ay, in_ax}),
    .in_b         ({in_bz, in_by, in_bx}),
    .in_c         ({in_cz, in_cy, in_cx}),
    .in_last      (in_last_triangle),
    .cmd          (cmd),
    .stat         (stat),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .hit_found    (out_hit_found),
    .hit_index    (out_hit_index),
    .hit_x        (out_hit_x),
    .hit_y        (out_hit_y),
    .hit_z        (out_hit_z),
    .hit_distance (out_hit_distance)
  );

  `RTNH_ASSERT_SAME(a_accept_loads, clk, rst_n, in_accept, cmd.load_tri)
  `RTNH_ASSERT_SAME(a_out_load_free, clk, rst_n, cmd.out_load, stat.out_free)
  `RTNH_ASSERT_NEXT(a_out_load_valid, clk, rst_n, cmd.out_load, out_valid)
  `RTNH_ASSERT_NEXT(a_mul_done_once, clk, rst_n, stat.mul_done, !stat.mul_done)
endmodule

// ===== sim/rtnh_checker.sv =====
// Checker for ray_triangle_nearest_hit: tracks segment registers, predicts nearest hits, compares.
`timescale 1ns / 1ps
module rtnh_checker import rtnh_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  coord_t      in_ax,
  input  coord_t      in_ay,
  input  coord_t      in_az,
  input  coord_t      in_bx,
  input  coord_t      in_by,
  input  coord_t      in_bz,
  input  coord_t      in_cx,
  input  coord_t      in_cy,
  input  coord_t      in_cz,
  input  logic        in_last_triangle,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        out_hit_found,
  input  logic [15:0] out_hit_index,
  input  coord_t      out_hit_x,
  input  coord_t      out_hit_y,
  input  coord_t      out_hit_z,
  input  logic [31:0] out_hit_distance,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          errors,
  output int          pending
);

  typedef struct packed {
    logic        found;
    logic [15:0] index;
    coord_t      x;
    coord_t      y;
    coord_t      z;
    logic [31:0] distance;
  } hit_rec_t;

  vec_t        seg_near, seg_far;
  logic        best_valid;
  logic [31:0] best_dist;
  logic [15:0] best_index, tri_count;
  vec_t        best_pt;
  hit_rec_t    nearest_hits[$];

  assign pending = nearest_hits.size();

  function automatic logic signed [127:0] volume(vec_t p, vec_t q, vec_t r, vec_t s);
    logic signed [127:0] u[3], v[3], w[3];
    logic signed [127:0] c0, c1, c2;
    for (int i = 0; i < 3; i++) begin
      u[i] = 128'($signed(q[i])) - 128'($signed(p[i]));
      v[i] = 128'($signed(r[i])) - 128'($signed(p[i]));
      w[i] = 128'($signed(s[i])) - 128'($signed(p[i]));
    end
    c0 = u[1] * v[2] - u[2] * v[1];
    c1 = u[2] * v[0] - u[0] * v[2];
    c2 = u[0] * v[1] - u[1] * v[0];
    return c0 * w[0] + c1 * w[1] + c2 * w[2];
  endfunction

  function automatic logic [31:0] root64(logic [63:0] x);
    logic [31:0] r, c;
    r = '0;
    for (int b = 31; b >= 0; b--) begin
      c = r | (32'd1 << b);
      if (64'(c) * 64'(c) <= x) r = c;
    end
    return r;
  endfunction

  task automatic absorb_triangle(input vec_t a, input vec_t b, input vec_t c, input logic last);
    logic signed [127:0] wn, wf, dw;
    logic [127:0]        num, den, dm, q, sq;
    logic [255:0]        qq;
    logic                s1, s2, s3;
    logic signed [63:0]  d;
    vec_t                pt;
    logic [31:0]         new_dist;
    logic [15:0]         idx;
    hit_rec_t            r;
    idx = tri_count;
    if (tri_count < CountLimit) tri_count++;
    wn = volume(seg_near, a, b, c);
    wf = volume(seg_far, a, b, c);
    if ((wn < 0) != (wf < 0)) begin
      s1 = volume(seg_near, seg_far, a, b) < 0;
      s2 = volume(seg_near, seg_far, b, c) < 0;
      s3 = volume(seg_near, seg_far, c, a) < 0;
      if (s1 == s2 && s2 == s3) begin
        num = wn < 0 ? -wn : wn;
        dw  = wn - wf;
        den = dw < 0 ? -dw : dw;
        sq  = '0;
        for (int i = 0; i < 3; i++) begin
          d  = 64'($signed(seg_far[i])) - 64'($signed(seg_near[i]));
          dm = d < 0 ? 128'(-d) : 128'(d);
          qq = ({128'd0, dm} * {128'd0, num} * 2 + {128'd0, den}) / ({128'd0, den} * 2);
          q  = qq[127:0];
          sq = sq + q * q;
          pt[i] = d < 0 ? seg_near[i] - q[31:0] : seg_near[i] + q[31:0];
        end
        new_dist = (sq >> 64) != 0 ? 32'hFFFF_FFFF : root64(sq[63:0]);
        if (!best_valid || new_dist < best_dist) begin
          best_valid = 1'b1;
          best_dist  = new_dist;
          best_index = idx;
          best_pt    = pt;
        end
      end
    end
    if (last) begin
      r.found    = best_valid;
      r.index    = best_valid ? best_index : '0;
      r.x        = best_valid ? best_pt[0] : '0;
      r.y        = best_valid ? best_pt[1] : '0;
      r.z        = best_valid ? best_pt[2] : '0;
      r.distance = best_valid ? best_dist : '0;
      nearest_hits = {nearest_hits, r};
      best_valid = 1'b0;
      best_dist  = '0;
      best_index = '0;
      best_pt    = '0;
      tri_count  = '0;
    end
  endtask

  task automatic flag_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    hit_rec_t e;
    if (!rst_n) begin
      errors = 0;
      seg_near = '0;
      seg_far = '0;
      best_valid = 1'b0;
      best_dist = '0;
      best_index = '0;
      best_pt = '0;
      tri_count = '0;
      nearest_hits.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (nearest_hits.size() == 0) begin
          flag_mismatch("unexpected result transaction", 32'd1, 32'd0);
        end else begin
          e = nearest_hits.pop_front();
          if (out_hit_found !== e.found) flag_mismatch("hit_found", 32'(out_hit_found), 32'(e.found));
          if (out_hit_index !== e.index) flag_mismatch("hit_index", 32'(out_hit_index), 32'(e.index));
          if (out_hit_x !== e.x) flag_mismatch("hit_x", out_hit_x, e.x);
          if (out_hit_y !== e.y) flag_mismatch("hit_y", out_hit_y, e.y);
          if (out_hit_z !== e.z) flag_mismatch("hit_z", out_hit_z, e.z);
          if (out_hit_distance !== e.distance)
            flag_mismatch("hit_distance", out_hit_distance, e.distance);
        end
      end
      if (in_valid && !in_stall)
        absorb_triangle({in_az, in_ay, in_ax}, {in_bz, in_by, in_bx}, {in_cz, in_cy, in_cx},
                        in_last_triangle);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CfgNearX: seg_near[0] = cfg_data;
          CfgNearY: seg_near[1] = cfg_data;
          CfgNearZ: seg_near[2] = cfg_data;
          CfgFarX:  seg_far[0] = cfg_data;
          CfgFarY:  seg_far[1] = cfg_data;
          CfgFarZ:  seg_far[2] = cfg_data;
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== sim/tb.sv =====
// Testbench top for ray_triangle_nearest_hit: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb;
  import rtnh_pkg::*;

  localparam logic [2:0] CfgUnused = 3'd6;
  localparam int         RunLimit = 6000000;
  localparam int         DrainWait = 600;
  localparam int         HoldCycles = 8000;
  localparam coord_t     One = 32'h0001_0000;
  localparam coord_t     CMin = 32'h8000_0000;
  localparam coord_t     CMax = 32'h7FFF_FFFF;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  coord_t in_ax = '0, in_ay = '0, in_az = '0, in_bx = '0, in_by = '0, in_bz = '0;
  coord_t in_cx = '0, in_cy = '0, in_cz = '0;
  logic in_last_triangle = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_hit_found;
  logic [15:0] out_hit_index;
  coord_t out_hit_x, out_hit_y, out_hit_z;
  logic [31:0] out_hit_distance;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  int errors, pending;
  int in_idle = 0, out_idle = 0, hold_left = 0, cycles = 0;
  logic hold_req = 1'b0;
  logic hold_taken = 1'b0;
  vec_t seg_n, seg_f;

  always #10 clk = ~clk;

  ray_triangle_nearest_hit u_dut (.*);

  rtnh_checker u_chk (.*);

  always @(negedge clk) begin
    if (hold_req && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < out_idle);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > RunLimit) begin
      $display("ray_triangle_nearest_hit verification failed");
      $finish;
    end
  end

  task automatic send_tri(input vec_t a, input vec_t b, input vec_t c, input logic last);
    if ($urandom_range(99) < in_idle) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid <= 1'b1;
    {in_ax, in_ay, in_az} <= {a[0], a[1], a[2]};
    {in_bx, in_by, in_bz} <= {b[0], b[1], b[2]};
    {in_cx, in_cy, in_cz} <= {c[0], c[1], c[2]};
    in_last_triangle <= last;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic wait_results();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_segment(input vec_t n, input vec_t f);
    logic [2:0] idx[7];
    coord_t val[7];
    idx = '{CfgNearX, CfgNearY, CfgNearZ, CfgFarX, CfgFarY, CfgFarZ, CfgUnused};
    val = '{n[0], n[1], n[2], f[0], f[1], f[2], $urandom};
    wait_results();
    repeat (DrainWait) @(negedge clk);
    for (int i = 0; i < 7; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= val[i];
      do @(posedge clk); while (!cfg_ready);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
    seg_n = n;
    seg_f = f;
  endtask

  function automatic coord_t clamp32(longint v);
    if (v > longint'(2147483647)) return CMax;
    if (v < -longint'(2147483648)) return CMin;
    return coord_t'(v);
  endfunction

  // vertex near a point on the segment, spread by up to 2^k raw units per axis
  function automatic vec_t aimed_vertex(vec_t p, int k);
    vec_t r;
    for (int i = 0; i < 3; i++)
      r[i] = clamp32(longint'($signed(p[i])) + longint'($urandom_range(0, 2 << k))
                     - (longint'(1) << k));
    return r;
  endfunction

  function automatic vec_t rand_vec();
    vec_t r;
    for (int i = 0; i < 3; i++) r[i] = $urandom;
    return r;
  endfunction

  function automatic vec_t rand_seg_pt(int k);
    vec_t r;
    for (int i = 0; i < 3; i++)
      r[i] = k >= 31 ? coord_t'($urandom) : coord_t'($urandom_range(0, 2 << k) - (1 << k));
    return r;
  endfunction

  task automatic send_mesh(output int sent);
    int len, k;
    longint t, nv, fv;
    vec_t p, a, b, c;
    len = ($urandom_range(9) == 0) ? $urandom_range(8, 14) : $urandom_range(1, 6);
    for (int j = 0; j < len; j++) begin
      if ($urandom_range(99) < 80) begin
        t = $urandom_range(0, 256);
        for (int i = 0; i < 3; i++) begin
          nv = $signed(seg_n[i]);
          fv = $signed(seg_f[i]);
          p[i] = coord_t'(nv + ((fv - nv) * t) / 256);
        end
        k = $urandom_range(4, 26);
        a = aimed_vertex(p, k);
        b = aimed_vertex(p, k);
        c = aimed_vertex(p, k);
      end else begin
        a = rand_vec();
        b = rand_vec();
        c = rand_vec();
      end
      send_tri(a, b, c, j == len - 1);
    end
    sent = len;
  endtask

  initial begin
    int sent, done;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // segment along z from -10 to +10
    write_segment({-(10 * One), 32'd0, 32'd0}, {10 * One, 32'd0, 32'd0});
    send_tri({32'd0, -One, -One}, {32'd0, -One, 2 * One}, {32'd0, 2 * One, -One}, 1'b0);
    send_tri({-(5 * One), -One, -One}, {-(5 * One), -One, 2 * One},
             {-(5 * One), 2 * One, -One}, 1'b0);
    send_tri({-(5 * One), -One, -One}, {-(5 * One), 2 * One, -One},
             {-(5 * One), -One, 2 * One}, 1'b0);
    send_tri({One, One, One}, {One, One, One}, {One, One, One}, 1'b1);
    send_tri({32'd0, 5 * One, 5 * One}, {32'd0, 8 * One, 5 * One},
             {32'd0, 5 * One, 8 * One}, 1'b1);
    send_tri({CMin, CMin, CMin}, {CMax, CMax, CMax}, {32'd0, CMax, CMin}, 1'b0);
    send_tri({32'd0, CMin, CMin}, {32'd0, CMin, CMax}, {32'd0, CMax, 32'd0}, 1'b1);
    send_tri({-(10 * One), -One, -One}, {-(10 * One), -One, 2 * One},
             {-(10 * One), 2 * One, -One}, 1'b0);
    send_tri({10 * One, -One, -One}, {10 * One, -One, 2 * One},
             {10 * One, 2 * One, -One}, 1'b0);
    send_tri({10 * One, -One, -One}, {10 * One, 2 * One, -One},
             {10 * One, -One, 2 * One}, 1'b1);
    send_tri({CMax, CMax, CMax}, {CMin, CMin, CMin}, {CMax, CMin, CMax}, 1'b1);
    write_segment({CMin, CMin, CMin}, {CMax, CMax, CMax});
    send_tri({CMax, CMin, 32'd0}, {CMin, CMax, 32'd0}, {CMin, CMin, CMax}, 1'b0);
    send_tri({32'd0, CMin, CMax}, {CMax, 32'd0, CMin}, {CMin, CMax, 32'd0}, 1'b1);
    write_segment({One, One, One}, {One, One, One});
    send_tri({32'd0, 32'd0, CMin}, {32'd0, CMax, 32'd0}, {CMax, 32'd0, 32'd0}, 1'b1);

    for (int ph = 0; ph < 6; ph++) begin
      in_idle  = ph < 2 ? 30 : (ph < 4 ? 63 : 0);
      out_idle = ph < 2 ? 63 : (ph < 4 ? 30 : 0);
      case (ph)
        0: write_segment({CMin, CMax, CMin}, {CMax, CMin, CMax});
        1: write_segment(rand_seg_pt(31), rand_seg_pt(31));
        default: write_segment(rand_seg_pt($urandom_range(16, 24)),
                               rand_seg_pt($urandom_range(16, 24)));
      endcase
      if (ph == 4) hold_req = 1'b1;
      done = 0;
      while (done < 250) begin
        send_mesh(sent);
        done += sent;
        if (ph == 2 && done >= 120 && done - sent < 120) wait_results();
      end
    end

    wait_results();
    repeat (DrainWait) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("ray_triangle_nearest_hit verification clean");
    end else begin
      $display("ray_triangle_nearest_hit verification failed");
    end
    $finish;
  end

endmodule
